@@ sv/cpd_pkg.sv @@
`default_nettype none
package cpd_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LEN_SHIFT  = 2 * FRAC_BITS;
  localparam int DW         = COORD_BITS + 1;
  localparam int PW         = 2 * DW;
  localparam int SW         = PW + 1;
  localparam int SQ_AW      = 2 * ((SW + LEN_SHIFT + 1) / 2);
  localparam int RTW        = SQ_AW / 2;
  localparam int NUMW       = SW + FRAC_BITS;
  localparam int QW         = COORD_BITS + 1;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_QUERY    = 2'd1,
    OP_VALIDATE = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_INSIDE = 2'd0,
    REG_NEXT   = 2'd1,
    REG_PREV   = 2'd2,
    REG_VERTEX = 2'd3
  } region_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_NRD,
    S_NM1,
    S_NM2,
    S_NM3,
    S_LDA,
    S_LDB,
    S_LDC,
    S_LDP,
    S_MUL,
    S_EVAL,
    S_SQW,
    S_DIVW,
    S_VSQW,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         vertex_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } req_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic [1:0]         region;
    logic               polygon_ok;
    logic               saturated;
  } rsp_t;

endpackage
`default_nettype wire

@@ sv/convex_polygon_point_distance.sv @@
`default_nettype none
// channel  dir  handshake                 payload
// request  in   in_valid_i / in_stall_o   in_req_i   (cpd_pkg::req_t)
// result   out  out_valid_o / out_stall_i out_rsp_o  (cpd_pkg::rsp_t)
// config   in   cfg_we_i                  cfg_data_i (vertex_count)
// a write request gives no result
// a query walks every vertex on the shared multiplier, then runs per edge
// 4 loads, the multiply steps, 1 check, a root and a divide,
// then a vertex root before the result
// a validate request walks the vertices on the same multiplier
// a finished result waits in the output register while the next request is taken
// reset clears control state only; vertex memory is undefined until written
module convex_polygon_point_distance #(
  parameter int MAX_VERTICES = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire cpd_pkg::req_t   in_req_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output cpd_pkg::rsp_t        out_rsp_o,
  input  wire logic            cfg_we_i,
  input  wire logic [4:0]      cfg_data_i
);
  import cpd_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = COORD_BITS;
  localparam int RW = RTW + 1;
  localparam logic signed [RW-1:0] R_HI = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] R_LO = -R_HI - RW'(1);

  function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] i, input logic [NW-1:0] n);
    logic [NW-1:0] s;
    s = NW'(i) + NW'(1);
    return (s >= n) ? '0 : IW'(s);
  endfunction

  state_e state_q, state_d;

  logic [4:0]              cnt_q;
  logic                    val_q, val_d;
  logic [NW-1:0]           n_q, n_d, n_in;
  logic [IW-1:0]           idx_q, idx_d, best_q, best_d;
  logic [PW-1:0]           bd_q, bd_d;
  logic                    edge_q, edge_d;
  logic signed [CW-1:0]    ptx_q, ptx_d, pty_q, pty_d;
  logic signed [CW-1:0]    ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [2:0]              mstep_q, mstep_d, tag_q;
  logic                    tv_q;
  logic signed [SW-1:0]    len2_q, len2_d, dot_q, dot_d, cross_q, cross_d, acc_q, acc_d;
  logic                    p0_q, p0_d, p1_q, p1_d, ok_q, ok_d;
  logic signed [QW:0]      d0_q, d0_d, d1_q, d1_d;
  logic [RTW-1:0]          vdist_q, vdist_d;
  rsp_t                    out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic [2*CW-1:0]         rd_data;
  logic signed [CW-1:0]    rdx, rdy;
  logic [IW-1:0]           raddr, ia, ib, ic, prev_i, next_i;
  logic                    ram_we;
  logic signed [DW-1:0]    mul_a, mul_b, ex, ey, qx, qy, dx, dy;
  logic signed [PW-1:0]    prod;
  logic signed [SW-1:0]    psx, d2;
  logic                    mul_issue;
  logic                    sq_start, sq_done, dv_start, dv_done;
  logic [SQ_AW-1:0]        sq_arg;
  logic [RTW-1:0]          sq_root;
  logic [QW-1:0]           quot;
  logic [SW-1:0]           cross_abs;
  logic                    est;
  logic signed [QW:0]      est_v;
  logic                    out_free, accept;
  logic signed [RW-1:0]    r;
  region_e                 region;
  logic                    sat;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign n_in     = (int'(cnt_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(cnt_q);
  assign ram_we   = accept && (op_e'(in_req_i.operation) == OP_WRITE)
                 && (int'(in_req_i.vertex_index) < MAX_VERTICES);

  cpd_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTICES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IW'(in_req_i.vertex_index)),
    .wdata_i ({in_req_i.coord_x, in_req_i.coord_y}),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  cpd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  cpd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .arg_i   (sq_arg),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  cpd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   ({cross_abs, FRAC_BITS'(0)}),
    .den_i   (sq_root),
    .done_o  (dv_done),
    .quot_o  (quot)
  );

  assign rdx = rd_data[2*CW-1:CW];
  assign rdy = rd_data[CW-1:0];
  assign dx  = {ptx_q[CW-1], ptx_q} - {rdx[CW-1], rdx};
  assign dy  = {pty_q[CW-1], pty_q} - {rdy[CW-1], rdy};
  assign ex  = {bx_q[CW-1], bx_q} - {ax_q[CW-1], ax_q};
  assign ey  = {by_q[CW-1], by_q} - {ay_q[CW-1], ay_q};
  assign qx  = {ptx_q[CW-1], ptx_q} - {ax_q[CW-1], ax_q};
  assign qy  = {pty_q[CW-1], pty_q} - {ay_q[CW-1], ay_q};
  assign psx = {prod[PW-1], prod};
  assign d2  = acc_q + psx;
  assign cross_abs = cross_q[SW-1] ? SW'(-cross_q) : SW'(cross_q);

  assign prev_i = (best_q == '0) ? IW'(n_q - NW'(1)) : best_q - IW'(1);
  assign next_i = inc_wrap(best_q, n_q);

  always_comb begin
    if (val_q) begin
      ia = idx_q;
      ib = inc_wrap(idx_q, n_q);
      ic = inc_wrap(ib, n_q);
    end else begin
      ia = edge_q ? best_q : prev_i;
      ib = edge_q ? next_i : best_q;
      ic = ib;
    end
  end

  // final selection for a query
  always_comb begin
    if (d0_q < 0 && d1_q < 0) begin
      r      = (d0_q < d1_q) ? RW'(d0_q) : RW'(d1_q);
      region = REG_INSIDE;
    end else if (p1_q && d1_q >= 0) begin
      r      = RW'(d1_q);
      region = REG_NEXT;
    end else if (p0_q && d0_q >= 0) begin
      r      = RW'(d0_q);
      region = REG_PREV;
    end else begin
      r      = RW'(vdist_q);
      region = REG_VERTEX;
    end
    sat = 1'b0;
    if (r > R_HI) begin
      r   = R_HI;
      sat = 1'b1;
    end else if (r < R_LO) begin
      r   = R_LO;
      sat = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    n_d         = n_q;
    idx_d       = idx_q;
    best_d      = best_q;
    bd_d        = bd_q;
    edge_d      = edge_q;
    ptx_d       = ptx_q;
    pty_d       = pty_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    bx_d        = bx_q;
    by_d        = by_q;
    mstep_d     = mstep_q;
    len2_d      = len2_q;
    dot_d       = dot_q;
    cross_d     = cross_q;
    acc_d       = acc_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    ok_d        = ok_q;
    d0_d        = d0_q;
    d1_d        = d1_q;
    vdist_d     = vdist_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    raddr       = idx_q;
    mul_a       = dx;
    mul_b       = dx;
    mul_issue   = 1'b0;
    sq_start    = 1'b0;
    sq_arg      = SQ_AW'({len2_q, LEN_SHIFT'(0)});
    dv_start    = 1'b0;
    est         = 1'b0;
    est_v       = '0;

    if (tv_q) begin
      case (tag_q)
        3'd0:    len2_d  = psx;
        3'd1:    len2_d  = len2_q + psx;
        3'd2:    dot_d   = psx;
        3'd3:    dot_d   = dot_q + psx;
        3'd4:    cross_d = psx;
        3'd5:    cross_d = cross_q - psx;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d  = '0;
          edge_d = 1'b0;
          n_d    = n_in;
          unique case (op_e'(in_req_i.operation))
            OP_QUERY: begin
              val_d   = 1'b0;
              ok_d    = 1'b0;
              ptx_d   = in_req_i.coord_x;
              pty_d   = in_req_i.coord_y;
              state_d = (n_in == '0) ? S_FIN : S_NRD;
            end
            OP_VALIDATE: begin
              val_d   = 1'b1;
              ok_d    = (n_in >= NW'(2));
              state_d = (n_in >= NW'(2)) ? S_LDA : S_FIN;
            end
            OP_WRITE, OP_NONE: ;
            default: ;
          endcase
        end
      end
      S_NRD: begin
        raddr   = idx_q;
        state_d = S_NM1;
      end
      S_NM1: begin
        mul_a   = dx;
        mul_b   = dx;
        state_d = S_NM2;
      end
      S_NM2: begin
        mul_a   = dy;
        mul_b   = dy;
        acc_d   = psx;
        state_d = S_NM3;
      end
      S_NM3: begin
        if (idx_q == '0 || d2[PW-1:0] < bd_q) begin
          bd_d   = d2[PW-1:0];
          best_d = idx_q;
        end
        if (NW'(idx_q) == n_q - NW'(1)) begin
          state_d = S_LDA;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_NRD;
        end
      end
      S_LDA: begin
        raddr   = ia;
        state_d = S_LDB;
      end
      S_LDB: begin
        ax_d    = rdx;
        ay_d    = rdy;
        raddr   = ib;
        state_d = S_LDC;
      end
      S_LDC: begin
        bx_d    = rdx;
        by_d    = rdy;
        raddr   = ic;
        state_d = S_LDP;
      end
      S_LDP: begin
        if (val_q) begin
          ptx_d = rdx;
          pty_d = rdy;
        end
        mstep_d = val_q ? 3'd4 : 3'd0;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (mstep_q == 3'd6) begin
          state_d = S_EVAL;
        end else begin
          mul_issue = 1'b1;
          mstep_d   = mstep_q + 3'd1;
          case (mstep_q)
            3'd0:    begin mul_a = ex; mul_b = ex; end
            3'd1:    begin mul_a = ey; mul_b = ey; end
            3'd2:    begin mul_a = ex; mul_b = qx; end
            3'd3:    begin mul_a = ey; mul_b = qy; end
            3'd4:    begin mul_a = ex; mul_b = qy; end
            default: begin mul_a = ey; mul_b = qx; end
          endcase
        end
      end
      S_EVAL: begin
        if (val_q) begin
          if (cross_q[SW-1]) begin
            ok_d    = 1'b0;
            state_d = S_FIN;
          end else if (NW'(idx_q) == n_q - NW'(1)) begin
            state_d = S_FIN;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_LDA;
          end
        end else begin
          if (edge_q) begin
            p1_d = (dot_q > 0) && (dot_q < len2_q);
          end else begin
            p0_d = (dot_q > 0) && (dot_q < len2_q);
          end
          sq_start = 1'b1;
          state_d  = S_SQW;
        end
      end
      S_SQW: begin
        if (sq_done) begin
          if (sq_root == '0) begin
            est = 1'b1;
          end else begin
            dv_start = 1'b1;
            state_d  = S_DIVW;
          end
        end
      end
      S_DIVW: begin
        if (dv_done) begin
          est   = 1'b1;
          est_v = cross_q[SW-1] ? {1'b0, quot} : -{1'b0, quot};
        end
      end
      S_VSQW: begin
        if (sq_done) begin
          vdist_d = sq_root;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (val_q) begin
            out_d.distance   = '0;
            out_d.region     = REG_INSIDE;
            out_d.polygon_ok = ok_q;
            out_d.saturated  = 1'b0;
          end else if (n_q == '0) begin
            out_d.distance   = '0;
            out_d.region     = REG_VERTEX;
            out_d.polygon_ok = 1'b0;
            out_d.saturated  = 1'b0;
          end else begin
            out_d.distance   = r[CW-1:0];
            out_d.region     = region;
            out_d.polygon_ok = 1'b0;
            out_d.saturated  = sat;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // edge finished: keep its distance and move on
    if (est) begin
      if (edge_q) begin
        d1_d     = est_v;
        sq_start = 1'b1;
        sq_arg   = SQ_AW'(bd_q);
        state_d  = S_VSQW;
      end else begin
        d0_d    = est_v;
        edge_d  = 1'b1;
        state_d = S_LDA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 5'd3;
      out_valid_q <= 1'b0;
      tv_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cnt_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
      tv_q        <= mul_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= mstep_q;
    val_q   <= val_d;
    n_q     <= n_d;
    idx_q   <= idx_d;
    best_q  <= best_d;
    bd_q    <= bd_d;
    edge_q  <= edge_d;
    ptx_q   <= ptx_d;
    pty_q   <= pty_d;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    mstep_q <= mstep_d;
    len2_q  <= len2_d;
    dot_q   <= dot_d;
    cross_q <= cross_d;
    acc_q   <= acc_d;
    p0_q    <= p0_d;
    p1_q    <= p1_d;
    ok_q    <= ok_d;
    d0_q    <= d0_d;
    d1_q    <= d1_d;
    vdist_q <= vdist_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

@@ sv/cpd_ram.sv @@
`default_nettype none
module cpd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ sv/cpd_mul.sv @@
`default_nettype none
module cpd_mul (
  input  wire logic                       clk_i,
  input  wire logic signed [cpd_pkg::DW-1:0] a_i,
  input  wire logic signed [cpd_pkg::DW-1:0] b_i,
  output logic signed [cpd_pkg::PW-1:0]      p_o
);
  import cpd_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule
`default_nettype wire

@@ sv/cpd_sqrt.sv @@
`default_nettype none
module cpd_sqrt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [cpd_pkg::SQ_AW-1:0]    arg_i,
  output logic                              done_o,
  output logic [cpd_pkg::RTW-1:0]           root_o
);
  import cpd_pkg::*;

  localparam int CNTW = $clog2(RTW);

  logic              busy_q, busy_d, done_q, done_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic [SQ_AW-1:0]  rad_q, rad_d;
  logic [RTW+1:0]    rem_q, rem_d;
  logic [RTW-1:0]    root_q, root_d;
  logic [RTW+2:0]    rem2, trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    rem2   = {rem_q[RTW:0], rad_q[SQ_AW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = arg_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[SQ_AW-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem_d  = RTW'(0) + (RTW+2)'(rem2 - trial);
        root_d = {root_q[RTW-2:0], 1'b1};
      end else begin
        rem_d  = (RTW+2)'(rem2);
        root_d = {root_q[RTW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(RTW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

@@ sv/cpd_div.sv @@
`default_nettype none
module cpd_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [cpd_pkg::NUMW-1:0]  num_i,
  input  wire logic [cpd_pkg::RTW-1:0]   den_i,
  output logic                           done_o,
  output logic [cpd_pkg::QW-1:0]         quot_o
);
  import cpd_pkg::*;

  localparam int CNTW = $clog2(NUMW);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic [NUMW-1:0]  nq_q, nq_d;
  logic [RTW:0]     rem_q, rem_d;
  logic [RTW-1:0]   den_q, den_d;
  logic [RTW:0]     rem2;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    rem2   = {rem_q[RTW-1:0], nq_q[NUMW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      nq_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem_d = rem2 - {1'b0, den_q};
        nq_d  = {nq_q[NUMW-2:0], 1'b1};
      end else begin
        rem_d = rem2;
        nq_d  = {nq_q[NUMW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(NUMW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // quotients past the result range are clamped
  assign done_o = done_q;
  assign quot_o = (|nq_q[NUMW-1:QW]) ? '1 : nq_q[QW-1:0];

endmodule
`default_nettype wire

@@ verif/convex_polygon_point_distance_test.sv @@
module convex_polygon_point_distance_test;
  import cpd_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam real PI = 3.14159265358979;

  class dist_scoreboard;
    longint vx[16];
    longint vy[16];
    logic [4:0] vcount = 5'd3;
    rsp_t expected_q[$];
    int errors;
    int checked;
    int region_hits[4];
    int sat_hits;
    int ok_hits;

    function void report(string what);
      errors++;
      $display("mismatch %0d: %s", errors, what);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [63:0] isqrt(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] t;
      logic [127:0] tt;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        t = r | (64'd1 << b);
        tt = t;
        if (tt * tt <= v) r = t;
      end
      return r;
    endfunction

    function wide_t cross_at(int a, int b, longint px, longint py);
      longint ex, ey, qx, qy;
      ex = vx[b] - vx[a];
      ey = vy[b] - vy[a];
      qx = px - vx[a];
      qy = py - vy[a];
      return wide_t'(ex) * wide_t'(qy) - wide_t'(ey) * wide_t'(qx);
    endfunction

    function longint edge_dist(int a, int b, longint px, longint py, output bit proj);
      longint ex, ey, qx, qy;
      wide_t len2, dot, cr;
      logic [127:0] len, mag;
      ex = vx[b] - vx[a];
      ey = vy[b] - vy[a];
      qx = px - vx[a];
      qy = py - vy[a];
      len2 = wide_t'(ex) * wide_t'(ex) + wide_t'(ey) * wide_t'(ey);
      dot = wide_t'(ex) * wide_t'(qx) + wide_t'(ey) * wide_t'(qy);
      cr = cross_at(a, b, px, py);
      proj = (dot > 0) && (dot < len2);
      len = isqrt(128'(len2) << 32);
      if (len == 0) return 0;
      mag = (cr < 0) ? -cr : cr;
      mag = (mag << 16) / len;
      if (mag > (128'd1 << 62)) mag = 128'd1 << 62;
      return (cr < 0) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function void note_request(req_t r);
      int n, best, prev, next;
      longint px, py, dx, dy, d0, d1, dval;
      wide_t bd, d2;
      bit p0, p1;
      rsp_t e;
      n = (vcount > 16) ? 16 : int'(vcount);
      px = {{32{r.coord_x[31]}}, r.coord_x};
      py = {{32{r.coord_y[31]}}, r.coord_y};
      e = '0;
      case (op_e'(r.operation))
        OP_WRITE: begin
          vx[r.vertex_index] = px;
          vy[r.vertex_index] = py;
        end
        OP_VALIDATE: begin
          e.polygon_ok = (n >= 2);
          for (int i = 0; i < n; i++)
            if (cross_at(i, (i + 1) % n, vx[(i + 2) % n], vy[(i + 2) % n]) < 0)
              e.polygon_ok = 1'b0;
          expected_q.push_back(e);
        end
        OP_QUERY: begin
          if (n == 0) begin
            e.region = REG_VERTEX;
          end else begin
            best = 0;
            bd = '0;
            for (int i = 0; i < n; i++) begin
              dx = px - vx[i];
              dy = py - vy[i];
              d2 = wide_t'(dx) * wide_t'(dx) + wide_t'(dy) * wide_t'(dy);
              if (i == 0 || d2 < bd) begin
                bd = d2;
                best = i;
              end
            end
            prev = (best == 0) ? n - 1 : best - 1;
            next = (best + 1 >= n) ? 0 : best + 1;
            d0 = -edge_dist(prev, best, px, py, p0);
            d1 = -edge_dist(best, next, px, py, p1);
            if (d0 < 0 && d1 < 0) begin
              dval = (d0 < d1) ? d0 : d1;
              e.region = REG_INSIDE;
            end else if (p1 && d1 >= 0) begin
              dval = d1;
              e.region = REG_NEXT;
            end else if (p0 && d0 >= 0) begin
              dval = d0;
              e.region = REG_PREV;
            end else begin
              dval = longint'(isqrt(128'(bd)));
              e.region = REG_VERTEX;
            end
            if (dval > 64'sd2147483647) begin
              dval = 64'sd2147483647;
              e.saturated = 1'b1;
            end
            if (dval < -64'sd2147483648) begin
              dval = -64'sd2147483648;
              e.saturated = 1'b1;
            end
            e.distance = dval[31:0];
          end
          expected_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: %h", got));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.distance !== e.distance)
        report($sformatf("distance %h, expected %h", got.distance, e.distance));
      if (got.region !== e.region)
        report($sformatf("region %0d, expected %0d", got.region, e.region));
      if (got.polygon_ok !== e.polygon_ok)
        report($sformatf("polygon_ok %b, expected %b", got.polygon_ok, e.polygon_ok));
      if (got.saturated !== e.saturated)
        report($sformatf("saturated %b, expected %b", got.saturated, e.saturated));
      region_hits[e.region]++;
      if (e.saturated) sat_hits++;
      if (e.polygon_ok) ok_hits++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_rsp_o;
  logic cfg_we_i;
  logic [4:0] cfg_data_i;

  dist_scoreboard sb = new;
  int cycles;
  int items;
  int idle_pct;
  int stall_pct;
  int hold_left;
  int cx, cy, rad;

  convex_polygon_point_distance dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i(in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o(out_rsp_o),
    .cfg_we_i(cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
  end

  task automatic put_req(op_e op, logic [3:0] idx, logic [31:0] x, logic [31:0] y);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i.operation = op;
    in_req_i.vertex_index = idx;
    in_req_i.coord_x = x;
    in_req_i.coord_y = y;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(in_req_i);
    if (op != OP_NONE) items++;
    @(negedge clk_i);
  endtask

  task automatic set_count(logic [4:0] c);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_data_i = c;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.vcount = c;
  endtask

  task automatic load_polygon(int n, bit clean);
    int nn, e;
    real base, ang, jit;
    nn = (n < 2) ? 2 : ((n > 16) ? 16 : n);
    e = $urandom_range(4, 28);
    rad = (1 << e) + $urandom_range(0, (1 << e) - 1);
    cx = $urandom_range(0, 1 << 30) - (1 << 29);
    cy = $urandom_range(0, 1 << 30) - (1 << 29);
    base = $urandom_range(0, 999) * 2.0 * PI / 1000.0;
    for (int k = 0; k < nn; k++) begin
      if (clean) begin
        jit = ($urandom_range(0, 100) / 100.0 - 0.5) * 0.8 * PI / nn;
        ang = base + 2.0 * PI * k / nn + jit;
        put_req(OP_WRITE, 4'(k), cx + $rtoi(rad * $cos(ang)), cy + $rtoi(rad * $sin(ang)));
      end else begin
        put_req(OP_WRITE, 4'($urandom_range(0, nn - 1)), $urandom, $urandom);
      end
    end
    put_req(OP_VALIDATE, 4'($urandom), $urandom, $urandom);
  endtask

  task automatic random_phase(int n, int target);
    int first, pick;
    first = items;
    load_polygon(n, 1'b1);
    while (items - first < target) begin
      pick = $urandom_range(99);
      if (pick < 8) load_polygon(n, pick < 6);
      else if (pick < 70)
        put_req(OP_QUERY, 4'($urandom),
                cx + $urandom_range(0, 4 * rad) - 2 * rad,
                cy + $urandom_range(0, 4 * rad) - 2 * rad);
      else if (pick < 85) put_req(OP_QUERY, 4'($urandom), $urandom, $urandom);
      else if (pick < 93) put_req(OP_VALIDATE, 4'($urandom), $urandom, $urandom);
      else if (pick < 96) put_req(OP_NONE, 4'($urandom), $urandom, $urandom);
      else put_req(OP_WRITE, 4'($urandom_range(n < 16 ? n : 15, 15)), $urandom, $urandom);
    end
  endtask

  localparam logic [31:0] ONE = 32'h0001_0000;

  initial begin
    logic [4:0] counts[10];
    counts = '{5'd16, 5'd2, 5'd1, 5'd0, 5'd31, 5'd5, 5'd8, 5'd3, 5'd12, 5'd16};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    out_stall_i = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // triangle in the first three slots, extremes in the rest
    put_req(OP_WRITE, 4'd0, 0, 0);
    put_req(OP_WRITE, 4'd1, 10 * ONE, 0);
    put_req(OP_WRITE, 4'd2, 0, 10 * ONE);
    put_req(OP_WRITE, 4'd3, 32'h7fff_ffff, 32'h7fff_ffff);
    put_req(OP_WRITE, 4'd4, 32'h8000_0000, 32'h8000_0000);
    for (int s = 5; s < 16; s++)
      put_req(OP_WRITE, 4'(s), (s & 1) ? 32'h8000_0000 : 32'h7fff_ffff, s * ONE);
    put_req(OP_VALIDATE, 4'hf, 32'hffff_ffff, 32'hffff_ffff);
    put_req(OP_QUERY, 4'd0, 2 * ONE, 2 * ONE);
    put_req(OP_QUERY, 4'd0, ONE, -3 * ONE);
    put_req(OP_QUERY, 4'd0, -3 * ONE, ONE);
    put_req(OP_QUERY, 4'd0, -3 * ONE, -3 * ONE);
    put_req(OP_QUERY, 4'd0, 32'h8000_0000, 32'h8000_0000);
    put_req(OP_QUERY, 4'd0, 32'h7fff_ffff, 32'h7fff_ffff);
    put_req(OP_NONE, 4'hf, 32'h7fff_ffff, 32'h8000_0000);

    for (int p = 0; p < 10; p++) begin
      set_count(counts[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      if (p == 5) hold_left = 3000;
      random_phase((counts[p] > 16) ? 16 : counts[p], 62);
    end

    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    $display("%0d requests, %0d results checked, vertex counts 0 to 31 incl. reset value",
             items, sb.checked);
    $display("regions in/next/prev/vertex %0d/%0d/%0d/%0d, %0d saturated, %0d valid polygons",
             sb.region_hits[0], sb.region_hits[1], sb.region_hits[2], sb.region_hits[3],
             sb.sat_hits, sb.ok_hits);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/cpd_pkg.sv
sv/cpd_ram.sv
sv/cpd_mul.sv
sv/cpd_sqrt.sv
sv/cpd_div.sv
sv/convex_polygon_point_distance.sv
verif/convex_polygon_point_distance_test.sv
